>>> rtl/brhp_pkg.sv
// ----------------------------------------------------------------------------
// brhp_pkg
// Shared types and constants of the byte-range header parser.
// ----------------------------------------------------------------------------
package brhp_pkg;

    localparam int CHAR_W     = 8;
    localparam int FIELD_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int PREFIX_LEN = 6;

    localparam logic [CHAR_W-1:0] CH_DASH  = "-";
    localparam logic [CHAR_W-1:0] CH_COMMA = ",";
    localparam logic [CHAR_W-1:0] CH_SPACE = " ";
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_UNSAT     = 2'd2
    } t_status;

    // Summary of the header handed from the parser to the resolver
    typedef struct packed {
        logic hdr_bad;
        logic dash;
        logic f_nonempty;
        logic f_bad;
        logic s_nonempty;
        logic s_bad;
    } t_job_flags;

    // Lower-case text of the leading token, one character per position
    function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = "b";
            3'd1:    ch = "y";
            3'd2:    ch = "t";
            3'd3:    ch = "e";
            3'd4:    ch = "s";
            3'd5:    ch = "=";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/brhp_if.sv
// ----------------------------------------------------------------------------
// brhp_char_if / brhp_result_if
// Valid/ready channels for header characters and parse results.
// ----------------------------------------------------------------------------
interface brhp_char_if;
    logic                         valid;
    logic                         ready;
    logic [brhp_pkg::CHAR_W-1:0]  text_char;
    logic                         last_char;
    logic [brhp_pkg::FIELD_W-1:0] file_size;

    modport source (output valid, output text_char, output last_char, output file_size,
                    input ready);
    modport sink   (input valid, input text_char, input last_char, input file_size,
                    output ready);
endinterface

interface brhp_result_if;
    logic                          valid;
    logic                          ready;
    logic [brhp_pkg::STATUS_W-1:0] status;
    logic [brhp_pkg::FIELD_W-1:0]  range_start;
    logic [brhp_pkg::FIELD_W-1:0]  range_end;

    modport source (output valid, output status, output range_start, output range_end,
                    input ready);
    modport sink   (input valid, input status, input range_start, input range_end,
                    output ready);
endinterface

>>> rtl/byte_range_header_parser.sv
// ----------------------------------------------------------------------------
// byte_range_header_parser
// Parses a byte-range header value, one character per transfer, into a
// status and an inclusive offset range clamped to the resource size.
// ----------------------------------------------------------------------------
// The header value streams in at one character per clock while the queue has
// room; the character parser keeps no more than one multiply-by-ten add per
// cycle, so the input never waits on the text. The transfer carrying last_char
// (with file_size) closes the header; its result enters the queue, passes the
// two resolver stages and is presented on the output channel once they have
// clamped it. Finished headers wait in a two-entry queue, so input ready drops
// only when that queue is full because results are not being taken.
// Offsets and the size are handled at OFFSET_WIDTH bits and zero-extended
// on the 64-bit result fields.
// ----------------------------------------------------------------------------
module byte_range_header_parser #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brhp_char_if.sink     i_char,
    brhp_result_if.source o_result
);

    localparam int JOB_W = $bits(brhp_pkg::t_job_flags) + 3 * OFFSET_WIDTH;
    localparam int QUEUE_DEPTH = 2;

    logic                    push;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    brhp_pkg::t_job_flags    f_flags;
    logic [OFFSET_WIDTH-1:0] f_first;
    logic [OFFSET_WIDTH-1:0] f_second;
    logic [OFFSET_WIDTH-1:0] f_size;
    logic [JOB_W-1:0]        q_in;
    logic [JOB_W-1:0]        q_out;
    brhp_pkg::t_job_flags    b_flags;
    logic [OFFSET_WIDTH-1:0] b_first;
    logic [OFFSET_WIDTH-1:0] b_second;
    logic [OFFSET_WIDTH-1:0] b_size;
    brhp_pkg::t_status       res_status;
    logic [OFFSET_WIDTH-1:0] res_start;
    logic [OFFSET_WIDTH-1:0] res_end;

    brhp_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_char.valid),
        .o_ready     (i_char.ready),
        .i_text_char (i_char.text_char),
        .i_last_char (i_char.last_char),
        .i_file_size (i_char.file_size[OFFSET_WIDTH-1:0]),
        .i_full      (q_full),
        .o_push      (push),
        .o_flags     (f_flags),
        .o_first     (f_first),
        .o_second    (f_second),
        .o_size      (f_size)
    );

    assign q_in = {f_flags, f_first, f_second, f_size};

    brhp_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    assign {b_flags, b_first, b_second, b_size} = q_out;

    brhp_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_flags  (b_flags),
        .i_first  (b_first),
        .i_second (b_second),
        .i_size   (b_size),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_status (res_status),
        .o_start  (res_start),
        .o_end    (res_end)
    );

    assign o_result.status      = res_status;
    assign o_result.range_start = brhp_pkg::FIELD_W'(res_start);
    assign o_result.range_end   = brhp_pkg::FIELD_W'(res_end);

endmodule

>>> rtl/brhp_front.sv
// ----------------------------------------------------------------------------
// brhp_front
// Character parser: prefix match, two decimal accumulators sharing one
// multiply-by-ten adder, and a job push on the final character.
// ----------------------------------------------------------------------------
module brhp_front #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [brhp_pkg::CHAR_W-1:0]   i_text_char,
    input  logic                          i_last_char,
    input  logic [OFFSET_WIDTH-1:0]       i_file_size,
    input  logic                          i_full,
    output logic                          o_push,
    output brhp_pkg::t_job_flags          o_flags,
    output logic [OFFSET_WIDTH-1:0]       o_first,
    output logic [OFFSET_WIDTH-1:0]       o_second,
    output logic [OFFSET_WIDTH-1:0]       o_size
);

    localparam int ACC_W = OFFSET_WIDTH + 4;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_FIRST  = 5'b00100,
        PH_SECOND = 5'b01000,
        PH_SKIP   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic nonempty;
        logic closed;
        logic bad;
    } t_num_flags;

    t_phase                  r_phase,  n_phase;
    logic [2:0]              r_pos,    n_pos;
    logic [OFFSET_WIDTH-1:0] r_first,  n_first;
    logic [OFFSET_WIDTH-1:0] r_second, n_second;
    t_num_flags              r_fnf,    n_fnf;
    t_num_flags              r_snf,    n_snf;
    logic                    r_hdr_bad, n_hdr_bad;
    logic                    r_dash,    n_dash;

    logic                    accept;
    logic                    blank;
    logic                    digit;
    logic [brhp_pkg::CHAR_W-1:0] lc;
    logic                    pref_ok;
    logic                    sel_second;
    logic [OFFSET_WIDTH-1:0] acc;
    t_num_flags              nf;
    logic [ACC_W-1:0]        acc_wide;
    logic [ACC_W-1:0]        mul_sum;
    logic [OFFSET_WIDTH-1:0] num_upd;
    t_num_flags              nf_upd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && i_last_char;

    assign blank = (i_text_char == brhp_pkg::CH_SPACE) || (i_text_char == brhp_pkg::CH_TAB) ||
                   (i_text_char == brhp_pkg::CH_CR)    || (i_text_char == brhp_pkg::CH_LF);
    assign digit = (i_text_char >= "0") && (i_text_char <= "9");
    assign lc    = ((i_text_char >= "A") && (i_text_char <= "Z")) ? i_text_char + 8'd32
                                                                   : i_text_char;
    assign pref_ok = (r_pos < 3'(brhp_pkg::PREFIX_LEN)) && (lc == brhp_pkg::prefix_char(r_pos));

    // One accumulator is live at a time: share the times-ten adder
    assign sel_second = (r_phase == PH_SECOND);
    assign acc        = sel_second ? r_second : r_first;
    assign nf         = sel_second ? r_snf : r_fnf;
    assign acc_wide   = ACC_W'(acc);
    assign mul_sum    = (acc_wide << 3) + (acc_wide << 1) + ACC_W'(i_text_char[3:0]);

    always_comb begin
        nf_upd  = nf;
        num_upd = acc;
        if (blank) begin
            if (nf.nonempty) begin
                nf_upd.closed = 1'b1;
            end
        end else begin
            if (nf.closed) begin
                nf_upd.bad = 1'b1;
            end
            nf_upd.nonempty = 1'b1;
            if (!digit) begin
                nf_upd.bad = 1'b1;
            end else if (!(nf.bad || nf.closed)) begin
                if (mul_sum[ACC_W-1:OFFSET_WIDTH] != 4'd0) begin
                    nf_upd.bad = 1'b1;
                end else begin
                    num_upd = mul_sum[OFFSET_WIDTH-1:0];
                end
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_first   = r_first;
        n_second  = r_second;
        n_fnf     = r_fnf;
        n_snf     = r_snf;
        n_hdr_bad = r_hdr_bad;
        n_dash    = r_dash;
        unique case (r_phase)
            PH_LEAD, PH_PREFIX: begin
                // leading blanks are skipped; the first other byte opens the prefix
                if ((r_phase == PH_PREFIX) || !blank) begin
                    if (!pref_ok) begin
                        n_hdr_bad = 1'b1;
                        n_phase   = PH_SKIP;
                    end else begin
                        n_pos   = r_pos + 3'd1;
                        n_phase = (r_pos == 3'(brhp_pkg::PREFIX_LEN - 1)) ? PH_FIRST
                                                                          : PH_PREFIX;
                    end
                end
            end
            PH_FIRST: begin
                if (i_text_char == brhp_pkg::CH_COMMA) begin
                    n_hdr_bad = 1'b1;
                    n_phase   = PH_SKIP;
                end else if (i_text_char == brhp_pkg::CH_DASH) begin
                    n_dash  = 1'b1;
                    n_phase = PH_SECOND;
                end else begin
                    n_first = num_upd;
                    n_fnf   = nf_upd;
                end
            end
            PH_SECOND: begin
                // drop everything after the first comma
                if (i_text_char == brhp_pkg::CH_COMMA) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_second = num_upd;
                    n_snf    = nf_upd;
                end
            end
            PH_SKIP: begin
                n_phase = PH_SKIP;
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
    end

    assign o_flags.hdr_bad    = n_hdr_bad;
    assign o_flags.dash       = n_dash;
    assign o_flags.f_nonempty = n_fnf.nonempty;
    assign o_flags.f_bad      = n_fnf.bad;
    assign o_flags.s_nonempty = n_snf.nonempty;
    assign o_flags.s_bad      = n_snf.bad;
    assign o_first            = n_first;
    assign o_second           = n_second;
    assign o_size             = i_file_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase   <= PH_LEAD;
            r_pos     <= 3'd0;
            r_first   <= '0;
            r_second  <= '0;
            r_fnf     <= '0;
            r_snf     <= '0;
            r_hdr_bad <= 1'b0;
            r_dash    <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_first   <= n_first;
            r_second  <= n_second;
            r_fnf     <= n_fnf;
            r_snf     <= n_snf;
            r_hdr_bad <= n_hdr_bad;
            r_dash    <= n_dash;
        end
    end

endmodule

>>> rtl/brhp_queue.sv
// ----------------------------------------------------------------------------
// brhp_queue
// Small register queue of finished headers between parser and resolver.
// ----------------------------------------------------------------------------
module brhp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/brhp_back.sv
// ----------------------------------------------------------------------------
// brhp_back
// Range resolver: clamps and checks the parsed numbers against the size in
// two registered stages, the second one being the output register.
// ----------------------------------------------------------------------------
module brhp_back #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  brhp_pkg::t_job_flags          i_flags,
    input  logic [OFFSET_WIDTH-1:0]       i_first,
    input  logic [OFFSET_WIDTH-1:0]       i_second,
    input  logic [OFFSET_WIDTH-1:0]       i_size,
    output logic                          o_valid,
    input  logic                          i_ready,
    output brhp_pkg::t_status             o_status,
    output logic [OFFSET_WIDTH-1:0]       o_start,
    output logic [OFFSET_WIDTH-1:0]       o_end
);

    logic                    r_s1_valid;
    brhp_pkg::t_status       r_s1_status, n_s1_status;
    logic                    r_s1_check,  n_s1_check;
    logic [OFFSET_WIDTH-1:0] r_s1_start,  n_s1_start;
    logic [OFFSET_WIDTH-1:0] r_s1_end,    n_s1_end;

    logic                    r_out_valid;
    brhp_pkg::t_status       r_out_status, n_out_status;
    logic [OFFSET_WIDTH-1:0] r_out_start;
    logic [OFFSET_WIDTH-1:0] r_out_end;

    logic                    out_adv;
    logic                    s1_adv;
    logic [OFFSET_WIDTH-1:0] last;
    logic [OFFSET_WIDTH-1:0] sfx_start;
    logic                    sfx_gt;
    logic                    start_ge;
    logic                    end_lt;

    assign out_adv = !r_out_valid || i_ready;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_pop   = i_valid && s1_adv;

    assign last      = i_size - OFFSET_WIDTH'(1);
    assign sfx_start = i_size - i_second;
    assign sfx_gt    = i_second > i_size;
    assign start_ge  = i_first >= i_size;
    assign end_lt    = i_second < last;

    always_comb begin
        n_s1_status = brhp_pkg::ST_OK;
        n_s1_check  = 1'b0;
        n_s1_start  = '0;
        n_s1_end    = '0;
        if (i_flags.hdr_bad || !i_flags.dash) begin
            n_s1_status = brhp_pkg::ST_MALFORMED;
        end else if (i_size == '0) begin
            n_s1_status = brhp_pkg::ST_UNSAT;
        end else if (!i_flags.f_nonempty) begin
            // suffix form: last N bytes, N clamped to the size
            if (!i_flags.s_nonempty || i_flags.s_bad || (i_second == '0)) begin
                n_s1_status = brhp_pkg::ST_UNSAT;
            end else begin
                n_s1_start = sfx_gt ? '0 : sfx_start;
                n_s1_end   = last;
            end
        end else if (i_flags.f_bad) begin
            n_s1_status = brhp_pkg::ST_MALFORMED;
        end else if (start_ge) begin
            n_s1_status = brhp_pkg::ST_UNSAT;
        end else if (i_flags.s_nonempty && i_flags.s_bad) begin
            n_s1_status = brhp_pkg::ST_MALFORMED;
        end else begin
            n_s1_start = i_first;
            n_s1_end   = (i_flags.s_nonempty && end_lt) ? i_second : last;
            n_s1_check = 1'b1;
        end
    end

    // reversed range after clamping is unsatisfiable
    assign n_out_status = (r_s1_check && (r_s1_end < r_s1_start)) ? brhp_pkg::ST_UNSAT
                                                                  : r_s1_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_status <= n_s1_status;
            r_s1_check  <= n_s1_check;
            r_s1_start  <= n_s1_start;
            r_s1_end    <= n_s1_end;
        end
        if (out_adv) begin
            r_out_status <= n_out_status;
            r_out_start  <= (n_out_status == brhp_pkg::ST_OK) ? r_s1_start : '0;
            r_out_end    <= (n_out_status == brhp_pkg::ST_OK) ? r_s1_end : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_start  = r_out_start;
    assign o_end    = r_out_end;

endmodule

>>> rtl/brhp_checker.sv
// ----------------------------------------------------------------------------
// brhp_checker
// Port-level checks of the byte-range header parser, bound to the top level.
// ----------------------------------------------------------------------------
module brhp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [brhp_pkg::STATUS_W-1:0] i_status,
    input logic [brhp_pkg::FIELD_W-1:0]  i_range_start,
    input logic [brhp_pkg::FIELD_W-1:0]  i_range_end
);

    // hold a stalled result unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_range_start) && $stable(i_range_end))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == brhp_pkg::ST_OK) || (i_status == brhp_pkg::ST_MALFORMED) ||
                        (i_status == brhp_pkg::ST_UNSAT))
        else $error("unknown status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != brhp_pkg::ST_OK) |->
            (i_range_start == '0) && (i_range_end == '0))
        else $error("non-zero range on an error result");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == brhp_pkg::ST_OK) |-> i_range_start <= i_range_end)
        else $error("valid range ends before it starts");

endmodule

bind byte_range_header_parser brhp_checker u_brhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_range_start (o_result.range_start),
    .i_range_end   (o_result.range_end)
);
